// ===== hdl/assert_macros.svh =====
// Assertion macros for the hop step RTL, used by the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lph_pkg.sv =====
// Types and constants of the lattice hop step block.
`timescale 1ns / 1ps
package lph_pkg;

    localparam int SITES  = 1024;

    localparam int POS_W  = 10;
    localparam int PROB_W = 16;
    localparam int POT_W  = 24;
    localparam int ENT_W  = 48;
    localparam int DISP_W = 32;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;
    localparam int SEL_W  = 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    localparam logic [SEL_W-1:0] SEL_LP_PLUS  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_RP_PLUS  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_LP_MINUS = 3'd2;
    localparam logic [SEL_W-1:0] SEL_RP_MINUS = 3'd3;
    localparam logic [SEL_W-1:0] SEL_DV_LEFT  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_DV_RIGHT = 3'd5;

    localparam logic [KIND_W-1:0] HOP_STAY  = 2'd0;
    localparam logic [KIND_W-1:0] HOP_LEFT  = 2'd1;
    localparam logic [KIND_W-1:0] HOP_RIGHT = 2'd2;

    localparam logic [1:0] REG_SITE_COUNT = 2'd0;
    localparam logic [1:0] REG_FLIP       = 2'd1;
    localparam logic [1:0] REG_VELOCITY   = 2'd2;

    // 1.0 in Q1.16
    localparam logic [PROB_W:0] PROB_ONE = 17'h10000;

    typedef struct packed {
        logic                    mode;
        logic [SEL_W-1:0]        sel;
        logic [POS_W-1:0]        pos;
        logic signed [POT_W-1:0] value;
        logic                    spin;
        logic [PROB_W-1:0]       rand_flip;
        logic [PROB_W-1:0]       rand_move;
        logic signed [ENT_W-1:0] entropy;
        logic signed [DISP_W-1:0] disp;
    } in_item_t;

    // step after table lookup; thresholds are raw until the divider finishes
    typedef struct packed {
        logic [POS_W-1:0]        x;
        logic                    spin;
        logic [PROB_W-1:0]       rand_flip;
        logic [PROB_W-1:0]       rand_move;
        logic signed [ENT_W-1:0] entropy;
        logic signed [DISP_W-1:0] disp;
        logic [POT_W-1:0]        dv_left;
        logic [POT_W-1:0]        dv_right;
        logic [PROB_W:0]         thr_left;
        logic [PROB_W:0]         thr_total;
    } hop_item_t;

endpackage

// ===== hdl/lph_front.sv =====
// Front end: accept, wrap position, table lookup/load, normalizing divider.
`timescale 1ns / 1ps
module lph_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lph_pkg::in_item_t        s_item,
    input  logic [lph_pkg::CNT_W-1:0] n_eff,
    output logic                     q_push,
    output lph_pkg::hop_item_t       q_item,
    input  logic                     q_full
);
    import lph_pkg::*;

    localparam int AW     = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int MOD_ST = POS_W / 2;
    localparam int DIV_ST = PROB_W / 2;
    localparam int MW     = POS_W + CNT_W;
    localparam int REM_W  = PROB_W + 2;

    function automatic logic [POS_W-1:0] mod_step(input logic [POS_W-1:0] rem,
                                                  input logic [CNT_W-1:0] n,
                                                  input int sh);
        logic [MW-1:0] nsh;
        logic [MW-1:0] r;
        nsh = MW'(n) << sh;
        r   = MW'(rem);
        if (r >= nsh) begin
            r = r - nsh;
        end
        return r[POS_W-1:0];
    endfunction

    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic [PROB_W:0] d);
        logic [REM_W-1:0] r2;
        r2 = {rem[REM_W-2:0], 1'b0};
        if (r2 >= REM_W'(d)) begin
            return {r2 - REM_W'(d), 1'b1};
        end
        return {r2, 1'b0};
    endfunction

    logic adv;

    // ---- modulo pipeline, two quotient bits per stage ----
    logic [MOD_ST-1:0] mod_vld_reg;
    in_item_t          mod_item_reg [MOD_ST];
    logic [POS_W-1:0]  mod_rem_reg  [MOD_ST];
    logic [POS_W-1:0]  mod_src      [MOD_ST];
    logic [POS_W-1:0]  mod_rem_next [MOD_ST];

    genvar k;
    generate
        for (k = 0; k < MOD_ST; k++) begin : g_mod
            if (k == 0) begin : g_first
                assign mod_src[k] = s_item.pos;
            end else begin : g_rest
                assign mod_src[k] = mod_rem_reg[k-1];
            end
            assign mod_rem_next[k] = mod_step(mod_step(mod_src[k], n_eff, POS_W - 1 - 2 * k),
                                              n_eff, POS_W - 2 - 2 * k);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_vld_reg <= '0;
        end else if (adv) begin
            mod_vld_reg <= {mod_vld_reg[MOD_ST-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mod_item_reg[0] <= s_item;
            for (int i = 1; i < MOD_ST; i++) begin
                mod_item_reg[i] <= mod_item_reg[i-1];
            end
            for (int i = 0; i < MOD_ST; i++) begin
                mod_rem_reg[i] <= mod_rem_next[i];
            end
        end
    end

    // ---- table stage ----
    in_item_t         mi;
    logic [POS_W-1:0] mx;
    logic             mv;
    logic             wr_ok;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;

    assign mi      = mod_item_reg[MOD_ST-1];
    assign mx      = mod_rem_reg[MOD_ST-1];
    assign mv      = mod_vld_reg[MOD_ST-1];
    assign wr_ok   = mv && (mi.mode == MODE_LOAD) && (32'(mi.pos) < 32'(SITES));
    assign wr_addr = AW'(mi.pos);
    assign rd_addr = AW'(mx);

    // probability tables are indexed by {spin, site}
    logic [PROB_W-1:0] lp_mem [2*SITES];
    logic [PROB_W-1:0] rp_mem [2*SITES];
    logic [POT_W-1:0]  dl_mem [SITES];
    logic [POT_W-1:0]  dr_mem [SITES];

    logic              rd_vld_reg;
    in_item_t          rd_item_reg;
    logic [POS_W-1:0]  rd_x_reg;
    logic [PROB_W-1:0] lp_rd_reg;
    logic [PROB_W-1:0] rp_rd_reg;
    logic [POT_W-1:0]  dl_rd_reg;
    logic [POT_W-1:0]  dr_rd_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (wr_ok) begin
                unique case (mi.sel)
                    SEL_LP_PLUS:  lp_mem[{1'b1, wr_addr}] <= mi.value[PROB_W-1:0];
                    SEL_RP_PLUS:  rp_mem[{1'b1, wr_addr}] <= mi.value[PROB_W-1:0];
                    SEL_LP_MINUS: lp_mem[{1'b0, wr_addr}] <= mi.value[PROB_W-1:0];
                    SEL_RP_MINUS: rp_mem[{1'b0, wr_addr}] <= mi.value[PROB_W-1:0];
                    SEL_DV_LEFT:  dl_mem[wr_addr] <= mi.value;
                    SEL_DV_RIGHT: dr_mem[wr_addr] <= mi.value;
                    default: ;
                endcase
            end
            lp_rd_reg   <= lp_mem[{mi.spin, rd_addr}];
            rp_rd_reg   <= rp_mem[{mi.spin, rd_addr}];
            dl_rd_reg   <= dl_mem[rd_addr];
            dr_rd_reg   <= dr_mem[rd_addr];
            rd_item_reg <= mi;
            rd_x_reg    <= mx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else if (adv) begin
            rd_vld_reg <= mv && (mi.mode == MODE_STEP);
        end
    end

    // ---- divider: floor(pl * 2^16 / sum), two bits per stage ----
    hop_item_t rd_hop;
    always_comb begin
        rd_hop.x         = rd_x_reg;
        rd_hop.spin      = rd_item_reg.spin;
        rd_hop.rand_flip = rd_item_reg.rand_flip;
        rd_hop.rand_move = rd_item_reg.rand_move;
        rd_hop.entropy   = rd_item_reg.entropy;
        rd_hop.disp      = rd_item_reg.disp;
        rd_hop.dv_left   = dl_rd_reg;
        rd_hop.dv_right  = dr_rd_reg;
        rd_hop.thr_left  = {1'b0, lp_rd_reg};
        rd_hop.thr_total = {1'b0, lp_rd_reg} + {1'b0, rp_rd_reg};
    end

    logic [DIV_ST-1:0] dv_vld_reg;
    hop_item_t         dv_item_reg [DIV_ST];
    logic [REM_W-1:0]  dv_rem_reg  [DIV_ST];
    logic [PROB_W-1:0] dv_q_reg    [DIV_ST];
    hop_item_t         dv_item_src [DIV_ST];
    logic [REM_W-1:0]  dv_rem_src  [DIV_ST];
    logic [PROB_W-1:0] dv_q_src    [DIV_ST];
    logic [REM_W-1:0]  dv_rem_next [DIV_ST];
    logic [PROB_W-1:0] dv_q_next   [DIV_ST];

    generate
        for (k = 0; k < DIV_ST; k++) begin : g_div
            logic [REM_W:0] t1;
            logic [REM_W:0] t2;
            if (k == 0) begin : g_first
                assign dv_item_src[k] = rd_hop;
                assign dv_rem_src[k]  = REM_W'(lp_rd_reg);
                assign dv_q_src[k]    = '0;
            end else begin : g_rest
                assign dv_item_src[k] = dv_item_reg[k-1];
                assign dv_rem_src[k]  = dv_rem_reg[k-1];
                assign dv_q_src[k]    = dv_q_reg[k-1];
            end
            assign t1 = div_step(dv_rem_src[k], dv_item_src[k].thr_total);
            assign t2 = div_step(t1[REM_W:1], dv_item_src[k].thr_total);
            assign dv_rem_next[k] = t2[REM_W:1];
            assign dv_q_next[k]   = {dv_q_src[k][PROB_W-3:0], t1[0], t2[0]};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg <= '0;
        end else if (adv) begin
            dv_vld_reg <= {dv_vld_reg[DIV_ST-2:0], rd_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < DIV_ST; i++) begin
                dv_item_reg[i] <= dv_item_src[i];
                dv_rem_reg[i]  <= dv_rem_next[i];
                dv_q_reg[i]    <= dv_q_next[i];
            end
        end
    end

    // sums over 1.0 normalize to 1.0, less one LSB if left quotient is inexact
    hop_item_t last;
    logic      norm;
    assign last = dv_item_reg[DIV_ST-1];
    assign norm = last.thr_total > PROB_ONE;

    always_comb begin
        q_item = last;
        if (norm) begin
            q_item.thr_left  = {1'b0, dv_q_reg[DIV_ST-1]};
            q_item.thr_total = PROB_ONE - (PROB_W + 1)'(dv_rem_reg[DIV_ST-1] != '0);
        end
    end

    // the whole front holds while its last stage waits on a full queue
    assign adv     = !(dv_vld_reg[DIV_ST-1] && q_full);
    assign s_ready = adv;
    assign q_push  = dv_vld_reg[DIV_ST-1] && !q_full;

endmodule

// ===== hdl/lph_queue.sv =====
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lph_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lph_pkg::hop_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               q_valid,
    output lph_pkg::hop_item_t q_item
);
    import lph_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    hop_item_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = count_reg == CW'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `ASSERT_IMP(a_no_push_when_full, aclk, aresetn, push, count_reg != CW'(QUEUE_DEPTH))
    `ASSERT_IMP(a_no_pop_when_empty, aclk, aresetn, pop, count_reg != '0)
    `ASSERT_NXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hdl/lph_back.sv =====
// Back end: hop decision, spin flip, position wrap, saturating accumulators, output register.
`timescale 1ns / 1ps
module lph_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  lph_pkg::hop_item_t               q_item,
    output logic                             pop,
    input  logic [lph_pkg::CNT_W-1:0]        n_eff,
    input  logic [lph_pkg::PROB_W-1:0]       flip_threshold,
    input  logic [lph_pkg::POT_W-1:0]        velocity_term,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [lph_pkg::POS_W-1:0]        m_new_position,
    output logic                             m_new_spin,
    output logic signed [lph_pkg::ENT_W-1:0] m_entropy_out,
    output logic signed [lph_pkg::DISP_W-1:0] m_displacement_out,
    output logic [lph_pkg::KIND_W-1:0]       m_hop_kind
);
    import lph_pkg::*;

    hop_item_t it;
    assign it = q_item;

    logic              left_hit;
    logic              right_hit;
    logic [CNT_W-1:0]  x_inc;
    logic [POS_W-1:0]  pos_left;
    logic [POS_W-1:0]  pos_right;
    logic [POT_W:0]    sv;
    logic [POT_W+1:0]  sv_ext;
    logic [POT_W+1:0]  dent;
    logic [ENT_W:0]    ent_sum;
    logic [DISP_W:0]   disp_sum;
    logic [DISP_W:0]   ddisp;

    logic [POS_W-1:0]  pos_next;
    logic [KIND_W-1:0] kind_next;
    logic [ENT_W-1:0]  ent_next;
    logic [DISP_W-1:0] disp_next;
    logic              spin_next;

    always_comb begin
        left_hit  = {1'b0, it.rand_move} < it.thr_left;
        right_hit = !left_hit && ({1'b0, it.rand_move} < it.thr_total);

        x_inc     = {1'b0, it.x} + 1'b1;
        pos_left  = (it.x == '0) ? POS_W'(n_eff - 1'b1) : it.x - 1'b1;
        pos_right = (x_inc == n_eff) ? '0 : x_inc[POS_W-1:0];

        sv     = it.spin ? {velocity_term[POT_W-1], velocity_term}
                         : -{velocity_term[POT_W-1], velocity_term};
        sv_ext = {sv[POT_W], sv};

        priority if (left_hit) begin
            pos_next  = pos_left;
            kind_next = HOP_LEFT;
            dent      = -sv_ext - {{2{it.dv_left[POT_W-1]}}, it.dv_left};
            ddisp     = '1;
        end else if (right_hit) begin
            pos_next  = pos_right;
            kind_next = HOP_RIGHT;
            dent      = sv_ext - {{2{it.dv_right[POT_W-1]}}, it.dv_right};
            ddisp     = (DISP_W + 1)'(1);
        end else begin
            pos_next  = it.x;
            kind_next = HOP_STAY;
            dent      = '0;
            ddisp     = '0;
        end

        ent_sum = {it.entropy[ENT_W-1], it.entropy}
                + {{(ENT_W - POT_W - 1){dent[POT_W+1]}}, dent};
        if (ent_sum[ENT_W] != ent_sum[ENT_W-1]) begin
            ent_next = ent_sum[ENT_W] ? {1'b1, {(ENT_W-1){1'b0}}} : {1'b0, {(ENT_W-1){1'b1}}};
        end else begin
            ent_next = ent_sum[ENT_W-1:0];
        end

        disp_sum = {it.disp[DISP_W-1], it.disp} + ddisp;
        if (disp_sum[DISP_W] != disp_sum[DISP_W-1]) begin
            disp_next = disp_sum[DISP_W] ? {1'b1, {(DISP_W-1){1'b0}}}
                                         : {1'b0, {(DISP_W-1){1'b1}}};
        end else begin
            disp_next = disp_sum[DISP_W-1:0];
        end

        spin_next = (it.rand_flip < flip_threshold) ? !it.spin : it.spin;
    end

    logic m_valid_reg;
    assign m_valid = m_valid_reg;
    assign pop     = q_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_new_position     <= pos_next;
            m_new_spin         <= spin_next;
            m_entropy_out      <= ent_next;
            m_displacement_out <= disp_next;
            m_hop_kind         <= kind_next;
        end
    end

endmodule

// ===== hdl/lattice_particle_hop_step.sv =====
// Top level of the lattice particle hop step block with its register port.
`timescale 1ns / 1ps
// Run-and-tumble Monte Carlo step for one particle on a periodic 1D lattice.
// Input channel (s_valid/s_ready): mode 0 items load one word into a hop
// probability or potential-step table and give no result; mode 1 items step
// one particle and give exactly one result on the m_ channel (m_valid/m_ready).
// Tables must be loaded before stepping; entries never written read garbage.
// Registers (APB, byte address 4*i): 0 site_count, 1 flip_threshold,
// 2 velocity_term. Write them only while no item is in flight.
// Throughput: one item per cycle unless a stalled receiver holds the front.
// Path to m_valid: 5 position wrap stages (two quotient bits each, the first
// loaded at accept), one table read stage, the 8-stage normalizing divider
// (two bits per stage), the queue write and the output register.
// A stalled receiver fills the 4-entry queue, then the front pipeline holds
// as a whole and s_ready drops. Loads pass the wrap stages and write the
// tables in order with steps, so a step sees every earlier load.
// Reset (aresetn low, synchronous) empties the pipelines and the queue and
// restores site_count 1024, flip_threshold 0, velocity_term 0; tables keep
// their contents and need no clearing pass.
module lattice_particle_hop_step (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [lph_pkg::SEL_W-1:0]         s_table_select,
    input  logic [lph_pkg::POS_W-1:0]         s_position,
    input  logic signed [lph_pkg::POT_W-1:0]  s_table_value,
    input  logic                              s_spin,
    input  logic [lph_pkg::PROB_W-1:0]        s_rand_flip,
    input  logic [lph_pkg::PROB_W-1:0]        s_rand_move,
    input  logic signed [lph_pkg::ENT_W-1:0]  s_entropy_in,
    input  logic signed [lph_pkg::DISP_W-1:0] s_displacement_in,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lph_pkg::POS_W-1:0]         m_new_position,
    output logic                              m_new_spin,
    output logic signed [lph_pkg::ENT_W-1:0]  m_entropy_out,
    output logic signed [lph_pkg::DISP_W-1:0] m_displacement_out,
    output logic [lph_pkg::KIND_W-1:0]        m_hop_kind
);
    import lph_pkg::*;

    // ---- registers ----
    logic [CNT_W-1:0]  site_count_reg;
    logic [PROB_W-1:0] flip_threshold_reg;
    logic [POT_W-1:0]  velocity_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_count_reg     <= 11'd1024;
            flip_threshold_reg <= '0;
            velocity_reg       <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SITE_COUNT: site_count_reg     <= pwdata[CNT_W-1:0];
                REG_FLIP:       flip_threshold_reg <= pwdata[PROB_W-1:0];
                REG_VELOCITY:   velocity_reg       <= pwdata[POT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SITE_COUNT: prdata = 32'(site_count_reg);
            REG_FLIP:       prdata = 32'(flip_threshold_reg);
            REG_VELOCITY:   prdata = {{(32 - POT_W){velocity_reg[POT_W-1]}}, velocity_reg};
            default:        prdata = '0;
        endcase
    end

    // site count in use, clamped to [2, SITES]
    logic [CNT_W-1:0] n_eff;
    always_comb begin
        priority if (site_count_reg < 11'd2) begin
            n_eff = 11'd2;
        end else if (32'(site_count_reg) > 32'(SITES)) begin
            n_eff = CNT_W'(SITES);
        end else begin
            n_eff = site_count_reg;
        end
    end

    // ---- datapath ----
    in_item_t  s_item;
    hop_item_t push_item;
    hop_item_t q_item;
    logic      q_push;
    logic      q_full;
    logic      q_valid;
    logic      q_pop;

    always_comb begin
        s_item.mode      = s_mode;
        s_item.sel       = s_table_select;
        s_item.pos       = s_position;
        s_item.value     = s_table_value;
        s_item.spin      = s_spin;
        s_item.rand_flip = s_rand_flip;
        s_item.rand_move = s_rand_move;
        s_item.entropy   = s_entropy_in;
        s_item.disp      = s_displacement_in;
    end

    lph_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .n_eff   (n_eff),
        .q_push  (q_push),
        .q_item  (push_item),
        .q_full  (q_full)
    );

    lph_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    lph_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .pop                (q_pop),
        .n_eff              (n_eff),
        .flip_threshold     (flip_threshold_reg),
        .velocity_term      (velocity_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_new_position     (m_new_position),
        .m_new_spin         (m_new_spin),
        .m_entropy_out      (m_entropy_out),
        .m_displacement_out (m_displacement_out),
        .m_hop_kind         (m_hop_kind)
    );

endmodule
